// ===== rtl/assert_macros.svh =====
// assertion helpers for the allocator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffpa_pkg.sv =====
package ffpa_pkg;
    localparam int MemUnits = 128;
    localparam int MaxParts = 128;
    localparam int JobBits  = 8;
    localparam int IdxW     = $clog2(MaxParts);
    localparam int CntW     = $clog2(MaxParts + 1);
    localparam int AddrW    = $clog2(MemUnits);
    localparam int LenW     = $clog2(MemUnits + 1);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_EXISTS  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_BADSIZE = 3'd4;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [AddrW-1:0]   start;
        logic [LenW-1:0]    len;
        logic               used;
        logic [JobBits-1:0] owner;
    } t_entry;
endpackage

// ===== rtl/first_fit_partition_allocator_unit.sv =====
// First-fit partition allocator. The partition table lives in a one-write,
// one-read memory walked by a small sequencer, one entry at a time; each read
// sets the address, then takes the registered data. A request first scans for
// the owning job. An allocate then scans for the first fit and, on a split,
// moves the tail up by one entry. A release reads its neighbors, writes the
// freed entry and closes one gap per merged neighbor, with one more write for
// the left merge. Ready is high only while idle; the result sits in an output
// register, so a new request is taken while it waits, and a finished request
// holds in its last state until the previous result is taken.
module first_fit_partition_allocator_unit import ffpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_job_number,
    input  logic [7:0] i_request_size,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [6:0] o_start_address,
    output logic [7:0] o_part_size
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_JRD   = 4'd2;
    localparam logic [3:0] S_JCHK  = 4'd3;
    localparam logic [3:0] S_FRD   = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_SHRD  = 4'd6;
    localparam logic [3:0] S_SHWR  = 4'd7;
    localparam logic [3:0] S_RCHK  = 4'd8;
    localparam logic [3:0] S_LCHK  = 4'd9;
    localparam logic [3:0] S_MRG   = 4'd10;
    localparam logic [3:0] S_LMRG  = 4'd11;
    localparam logic [3:0] S_DNRD  = 4'd12;
    localparam logic [3:0] S_DNWR  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]         r_state, n_state;
    logic [CntW-1:0]    r_count, n_count;
    logic [CntW-1:0]    r_i, n_i;
    logic [IdxW-1:0]    r_k, n_k;
    logic               r_op, n_op;
    logic [JobBits-1:0] r_job, n_job;
    logic [LenW-1:0]    r_size, n_size;
    logic [2:0]         r_st, n_st;
    logic [AddrW-1:0]   r_addr, n_addr;
    logic [LenW-1:0]    r_len, n_len;
    t_entry             r_hold, n_hold;   // entry being freed / rest of split
    t_entry             r_left, n_left;
    logic               r_rfree, n_rfree;
    logic               r_lfree, n_lfree;
    logic               r_ovalid, n_ovalid;
    logic [2:0]         r_ost, n_ost;
    logic [AddrW-1:0]   r_oaddr, n_oaddr;
    logic [LenW-1:0]    r_olen, n_olen;

    logic               we;
    logic [IdxW-1:0]    waddr, raddr;
    t_entry             wdata, rdata;

    ffpa_table u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state; n_count = r_count; n_i = r_i; n_k = r_k;
        n_op = r_op; n_job = r_job; n_size = r_size; n_st = r_st;
        n_addr = r_addr; n_len = r_len; n_hold = r_hold; n_left = r_left;
        n_rfree = r_rfree; n_lfree = r_lfree; n_ovalid = r_ovalid;
        n_ost = r_ost; n_oaddr = r_oaddr; n_olen = r_olen;
        we = 1'b0; waddr = r_i[IdxW-1:0]; wdata = rdata;
        raddr = r_i[IdxW-1:0];
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_INIT: begin
                we = 1'b1; waddr = '0;
                wdata = '0; wdata.len = LenW'(MemUnits);
                n_count = CntW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_op; n_job = i_job_number[JobBits-1:0];
                    n_size = LenW'(i_request_size);
                    n_i = '0; n_state = S_JRD;
                end
            end
            S_JRD: begin
                if (r_i == r_count) begin
                    // job not found
                    if (r_op == OP_RELEASE) begin
                        n_st = ST_UNKNOWN; n_state = S_OUT;
                    end else if (r_size == '0) begin
                        n_st = ST_BADSIZE; n_state = S_OUT;
                    end else begin
                        n_i = '0; n_state = S_FRD;
                    end
                end else begin
                    n_state = S_JCHK;
                end
            end
            S_JCHK: begin
                if (rdata.used && rdata.owner == r_job) begin
                    n_k = r_i[IdxW-1:0];
                    if (r_op == OP_ALLOC) begin
                        n_st = ST_EXISTS; n_state = S_OUT;
                    end else begin
                        n_st = ST_OK; n_addr = rdata.start; n_len = rdata.len;
                        n_hold = rdata; n_hold.used = 1'b0; n_hold.owner = '0;
                        n_lfree = 1'b0; n_rfree = 1'b0;
                        if (r_i + CntW'(1) < r_count) begin
                            raddr = IdxW'(r_i + CntW'(1)); n_state = S_RCHK;
                        end else if (r_i != '0) begin
                            raddr = IdxW'(r_i - CntW'(1)); n_state = S_LCHK;
                        end else begin
                            n_state = S_MRG;
                        end
                    end
                end else begin
                    n_i = r_i + CntW'(1); n_state = S_JRD;
                end
            end
            S_RCHK: begin
                if (!rdata.used) begin
                    n_rfree = 1'b1;
                    n_hold.len = r_hold.len + rdata.len;
                end
                if (r_k != '0) begin
                    raddr = r_k - IdxW'(1); n_state = S_LCHK;
                end else begin
                    n_state = S_MRG;
                end
            end
            S_LCHK: begin
                n_lfree = !rdata.used; n_left = rdata;
                n_state = S_MRG;
            end
            S_MRG: begin
                we = 1'b1; waddr = r_k; wdata = r_hold;
                if (r_rfree) begin
                    // close the gap left by the absorbed right neighbor
                    n_rfree = 1'b0;
                    n_i = CntW'(r_k) + CntW'(1); n_state = S_DNRD;
                end else if (r_lfree) begin
                    n_state = S_LMRG;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LMRG: begin
                we = 1'b1; waddr = r_k - IdxW'(1); wdata = r_left;
                wdata.len = r_left.len + r_hold.len;
                n_lfree = 1'b0;
                n_i = CntW'(r_k); n_state = S_DNRD;
            end
            S_DNRD: begin
                // move entry i+1 down to i until the end of the table
                if (r_i + CntW'(1) < r_count) begin
                    raddr = IdxW'(r_i + CntW'(1)); n_state = S_DNWR;
                end else begin
                    n_count = r_count - CntW'(1);
                    n_state = r_lfree ? S_LMRG : S_OUT;
                end
            end
            S_DNWR: begin
                we = 1'b1;
                n_i = r_i + CntW'(1); n_state = S_DNRD;
            end
            S_FRD: begin
                if (r_i == r_count) begin
                    n_st = ST_NOFIT; n_state = S_OUT;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (!rdata.used && rdata.len == r_size) begin
                    n_st = ST_OK; n_addr = rdata.start; n_len = r_size;
                    we = 1'b1; wdata = rdata;
                    wdata.used = 1'b1; wdata.owner = r_job;
                    n_state = S_OUT;
                end else if (!rdata.used && rdata.len > r_size &&
                             r_count < CntW'(MaxParts)) begin
                    n_st = ST_OK; n_addr = rdata.start; n_len = r_size;
                    n_k = r_i[IdxW-1:0];
                    we = 1'b1; wdata = rdata;
                    wdata.used = 1'b1; wdata.owner = r_job; wdata.len = r_size;
                    n_hold = '0;
                    n_hold.start = rdata.start + r_size[AddrW-1:0];
                    n_hold.len = rdata.len - r_size;
                    n_i = r_count; n_state = S_SHRD;
                end else begin
                    n_i = r_i + CntW'(1); n_state = S_FRD;
                end
            end
            S_SHRD: begin
                // move entry i-1 to i until the slot after k is open
                if (r_i == CntW'(r_k) + CntW'(1)) begin
                    we = 1'b1; wdata = r_hold;
                    n_count = r_count + CntW'(1);
                    n_state = S_OUT;
                end else begin
                    raddr = IdxW'(r_i - CntW'(1));
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                we = 1'b1;
                n_i = r_i - CntW'(1); n_state = S_SHRD;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ost = r_st;
                    n_oaddr = (r_st == ST_OK) ? r_addr : '0;
                    n_olen = (r_st == ST_OK) ? r_len : '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_count <= '0; r_ovalid <= 1'b0;
            r_i <= '0; r_k <= '0; r_rfree <= 1'b0; r_lfree <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_ovalid <= n_ovalid;
            r_i <= n_i; r_k <= n_k; r_rfree <= n_rfree; r_lfree <= n_lfree;
        end
        r_op <= n_op; r_job <= n_job; r_size <= n_size; r_st <= n_st;
        r_addr <= n_addr; r_len <= n_len; r_hold <= n_hold; r_left <= n_left;
        r_ost <= n_ost; r_oaddr <= n_oaddr; r_olen <= n_olen;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_ost;
    assign o_start_address = r_oaddr;
    assign o_part_size     = r_olen;
endmodule

// ===== rtl/ffpa_table.sv =====
module ffpa_table import ffpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IdxW-1:0]  i_waddr,
    input  t_entry           i_wdata,
    input  logic [IdxW-1:0]  i_raddr,
    output t_entry           o_rdata
);
    t_entry r_mem [MaxParts];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/ffpa_checker.sv =====
`include "assert_macros.svh"
module ffpa_checker import ffpa_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_status,
    input logic [6:0] o_start_address,
    input logic [7:0] o_part_size
);
    `CHK_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
              o_start_address == 7'd0 && o_part_size == 8'd0, "error result not zeroed")
    `CHK_IMPL(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_BADSIZE, "bad status")
    `CHK_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready,
              "ready after transfer")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status),
              "result dropped")
endmodule

bind first_fit_partition_allocator_unit ffpa_checker u_ffpa_checker (.*);
